// ----- hdl/mtx_pkg.sv -----
package mtx_pkg;

  localparam int STATE_WORDS = 624;
  localparam int MID = 397;

  localparam logic [31:0] INIT_MUL = 32'h6c07_8965;
  localparam logic [31:0] MATRIX = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C = 32'hefc6_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEED_FIRST,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_TW_PRE,
    ST_TW_CUR,
    ST_TW_RD,
    ST_TW_WR,
    ST_OUT_RD,
    ST_OUT_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SEED_FIRST,
    OP_SEED_MUL,
    OP_SEED_ADD,
    OP_TW_PRE,
    OP_TW_CUR,
    OP_TW_RD,
    OP_TW_WR,
    OP_OUT_RD,
    OP_OUT_EMIT
  } dp_op_t;

  typedef struct packed {
    logic first;
    logic idx_last;
    logic twist_due;
    logic out_free;
  } dp_status_t;

  function automatic logic [31:0] temper(input logic [31:0] r);
    logic [31:0] t;
    t = r ^ (r >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

// ----- hdl/mtx_in_if.sv -----
interface mtx_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_of_record;
  logic [31:0] seed;

  modport source (output valid, output data_byte, output first_of_record, output seed,
                  input ready);
  modport sink (input valid, input data_byte, input first_of_record, input seed,
                output ready);
endinterface

// ----- hdl/mtx_out_if.sv -----
interface mtx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink (input valid, input result_byte, output ready);
endinterface

// ----- hdl/mtx_ctrl.sv -----
module mtx_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mtx_pkg::dp_status_t status,
  output mtx_pkg::dp_op_t     op
);

  mtx_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtx_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op = mtx_pkg::OP_NONE;
    in_ready = 1'b0;
    unique case (state)
      mtx_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = mtx_pkg::OP_LATCH;
          state_next = mtx_pkg::ST_DECIDE;
        end
      end
      mtx_pkg::ST_DECIDE: begin
        priority if (status.first) begin
          state_next = mtx_pkg::ST_SEED_FIRST;
        end else if (status.twist_due) begin
          state_next = mtx_pkg::ST_TW_PRE;
        end else begin
          state_next = mtx_pkg::ST_OUT_RD;
        end
      end
      mtx_pkg::ST_SEED_FIRST: begin
        op = mtx_pkg::OP_SEED_FIRST;
        state_next = mtx_pkg::ST_SEED_MUL;
      end
      mtx_pkg::ST_SEED_MUL: begin
        op = mtx_pkg::OP_SEED_MUL;
        state_next = mtx_pkg::ST_SEED_ADD;
      end
      mtx_pkg::ST_SEED_ADD: begin
        op = mtx_pkg::OP_SEED_ADD;
        state_next = status.idx_last ? mtx_pkg::ST_TW_PRE : mtx_pkg::ST_SEED_MUL;
      end
      mtx_pkg::ST_TW_PRE: begin
        op = mtx_pkg::OP_TW_PRE;
        state_next = mtx_pkg::ST_TW_CUR;
      end
      mtx_pkg::ST_TW_CUR: begin
        op = mtx_pkg::OP_TW_CUR;
        state_next = mtx_pkg::ST_TW_RD;
      end
      mtx_pkg::ST_TW_RD: begin
        op = mtx_pkg::OP_TW_RD;
        state_next = mtx_pkg::ST_TW_WR;
      end
      mtx_pkg::ST_TW_WR: begin
        op = mtx_pkg::OP_TW_WR;
        state_next = status.idx_last ? mtx_pkg::ST_OUT_RD : mtx_pkg::ST_TW_RD;
      end
      mtx_pkg::ST_OUT_RD: begin
        op = mtx_pkg::OP_OUT_RD;
        state_next = mtx_pkg::ST_OUT_EMIT;
      end
      mtx_pkg::ST_OUT_EMIT: begin
        if (status.out_free) begin
          op = mtx_pkg::OP_OUT_EMIT;
          state_next = mtx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mtx_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/mtx_dp.sv -----
module mtx_dp #(
  parameter int STATE_WORDS = mtx_pkg::STATE_WORDS
) (
  input  logic                clk,
  input  logic                rst,
  input  mtx_pkg::dp_op_t     op,
  output mtx_pkg::dp_status_t status,
  input  logic [7:0]          data_byte,
  input  logic                first_of_record,
  input  logic [31:0]         seed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          result_byte
);

  localparam int IW = $clog2(STATE_WORDS);
  localparam int PW = $clog2(STATE_WORDS + 1);
  localparam logic [IW-1:0] LAST = IW'(STATE_WORDS - 1);
  localparam logic [IW-1:0] MID_OFS = IW'(mtx_pkg::MID);
  localparam logic [IW-1:0] WRAP_OFS = IW'(STATE_WORDS - mtx_pkg::MID);
  localparam logic [PW-1:0] WORDS_P = PW'(STATE_WORDS);

  logic [31:0] mem [STATE_WORDS];

  logic [7:0]    data_r;
  logic          first_r;
  logic [31:0]   seed_r;
  logic [31:0]   prev;
  logic [31:0]   prod;
  logic [31:0]   cur;
  logic [IW-1:0] idx;
  logic [PW-1:0] pos;
  logic          need;
  logic [31:0]   rd_a;
  logic [31:0]   rd_b;

  logic [IW-1:0] addr_a;
  logic [IW-1:0] addr_b;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [31:0]   seed_word;
  logic [31:0]   twist_word;
  logic [31:0]   twist_y;
  logic [31:0]   tempered;
  logic [PW-1:0] pos_inc;
  logic          idx_last;

  assign idx_last = (idx == LAST);
  assign pos_inc = pos + PW'(1);
  assign seed_word = prod + {{(32 - IW){1'b0}}, idx};
  assign twist_y = {cur[31], rd_a[30:0]};
  assign twist_word = (twist_y >> 1) ^ (rd_a[0] ? mtx_pkg::MATRIX : 32'h0) ^ rd_b;
  assign tempered = mtx_pkg::temper(rd_a);

  always_comb begin
    addr_a = pos[IW-1:0];
    addr_b = '0;
    unique case (op)
      mtx_pkg::OP_TW_PRE: begin
        addr_a = '0;
      end
      mtx_pkg::OP_TW_RD: begin
        addr_a = idx_last ? '0 : idx + IW'(1);
        addr_b = (idx < WRAP_OFS) ? idx + MID_OFS : idx - WRAP_OFS;
      end
      default: begin
        addr_a = pos[IW-1:0];
      end
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx;
    wr_data = seed_word;
    unique case (op)
      mtx_pkg::OP_SEED_FIRST: begin
        wr_en = 1'b1;
        wr_addr = '0;
        wr_data = seed_r;
      end
      mtx_pkg::OP_SEED_ADD: begin
        wr_en = 1'b1;
      end
      mtx_pkg::OP_TW_WR: begin
        wr_en = 1'b1;
        wr_data = twist_word;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // State words: one write and two registered reads per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    unique case (op)
      mtx_pkg::OP_LATCH: begin
        data_r <= data_byte;
        first_r <= first_of_record;
        seed_r <= seed;
      end
      mtx_pkg::OP_SEED_FIRST: begin
        prev <= seed_r;
        idx <= IW'(1);
      end
      mtx_pkg::OP_SEED_MUL: begin
        prod <= mtx_pkg::INIT_MUL * (prev ^ (prev >> 30));
      end
      mtx_pkg::OP_SEED_ADD: begin
        prev <= seed_word;
        idx <= idx + IW'(1);
      end
      mtx_pkg::OP_TW_PRE: begin
        idx <= '0;
      end
      mtx_pkg::OP_TW_CUR: begin
        cur <= rd_a;
      end
      mtx_pkg::OP_TW_WR: begin
        cur <= rd_a;
        idx <= idx + IW'(1);
      end
      default: begin
      end
    endcase
    if (op == mtx_pkg::OP_OUT_EMIT) begin
      result_byte <= data_r ^ tempered[8:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      need <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (op)
        mtx_pkg::OP_SEED_ADD: begin
          if (idx_last) begin
            pos <= '0;
            need <= 1'b1;
          end
        end
        mtx_pkg::OP_TW_WR: begin
          if (idx_last) begin
            pos <= '0;
            need <= 1'b0;
          end
        end
        mtx_pkg::OP_OUT_EMIT: begin
          pos <= pos_inc;
          need <= (pos_inc >= WORDS_P);
        end
        default: begin
        end
      endcase
      if (op == mtx_pkg::OP_OUT_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.first = first_r;
  assign status.idx_last = idx_last;
  assign status.twist_due = need || (pos >= WORDS_P);
  assign status.out_free = !out_valid || out_ready;

endmodule

// ----- hdl/mt19937_byte_keystream_xor_top.sv -----
// MT19937 keystream XOR. Each input word carries one data byte, a first-of-record
// flag and a 32-bit seed; each produces exactly one output word holding the data
// byte XORed with bits 8..1 of the next tempered MT19937 output. When the flag is
// set, the generator is first reseeded from the seed with the standard
// initialization, and the first byte after a reseed starts with a full twist.
// Bytes sent before the first reseed carry no meaningful keystream. The block
// works on one byte at a time: after acceptance a plain byte passes the decide,
// output read and emit states before the block is ready again. Every 624th
// byte, and the first byte after a reseed, also runs a twist over all 624
// words, and a reseed first writes all 624 words. Both are paced by the single
// 624-word state memory, which has one write port and two read ports with
// registered data, so each twisted word has a read step and then a write step,
// and by the seeding recurrence, which alternates a registered 32-bit multiply
// with an add and write. The result sits in an output register, so one that
// waits to be taken does not stop the next byte being accepted and worked on.
module mt19937_byte_keystream_xor_top #(
  parameter int STATE_WORDS = mtx_pkg::STATE_WORDS
) (
  input logic        clk,
  input logic        rst,
  mtx_in_if.sink     in_ch,
  mtx_out_if.source  out_ch
);

  mtx_pkg::dp_op_t     op;
  mtx_pkg::dp_status_t status;

  // The controller sequences seeding, twisting and output; it takes a new
  // word only while idle.
  mtx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .op       (op)
  );

  // The datapath holds the state memory, the seeding multiplier, the twist
  // logic, tempering and the output register.
  mtx_dp #(
    .STATE_WORDS (STATE_WORDS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .status          (status),
    .data_byte       (in_ch.data_byte),
    .first_of_record (in_ch.first_of_record),
    .seed            (in_ch.seed),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .result_byte     (out_ch.result_byte)
  );

endmodule

// ----- hdl/mtx_chk.sv -----
module mtx_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] result_byte
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Words accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_byte))
    else $error("output word changed or vanished while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != 2'd0)
    else $error("output word delivered without an accepted input word");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two words in flight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input accepted again before the previous word was started");

endmodule

bind mt19937_byte_keystream_xor_top mtx_chk u_mtx_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_byte (out_ch.result_byte)
);

// ----- tb/mt_keystream_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the MT19937 keystream XOR block. Every accepted
// input word is run through a local model of the generator, and the resulting
// byte waits in a queue until the matching output word is taken.
module mt_keystream_checker (
  input  logic      clk,
  input  logic      rst,
  mtx_in_if         in_mon,
  mtx_out_if        out_mon,
  input  logic      end_check,
  output int        errors,
  output int        pending
);

  localparam int          NWORDS     = mtx_pkg::STATE_WORDS;
  localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK = 32'h7fff_ffff;

  logic [31:0] mt_words [NWORDS];
  int unsigned draw_index;
  bit          twist_due;
  logic [7:0]  expected_bytes [$];
  logic [7:0]  want;
  int unsigned result_count;
  bit          leftovers_checked;

  task automatic report_mismatch(input string what);
    $display("%0t: keystream check: %s", $time, what);
    errors++;
  endtask

  function automatic void load_seed(input logic [31:0] s);
    logic [31:0] p;
    mt_words[0] = s;
    for (int i = 1; i < NWORDS; i++) begin
      p = mt_words[i-1];
      mt_words[i] = 32'(i) + mtx_pkg::INIT_MUL * (p ^ (p >> 30));
    end
    draw_index = 0;
    twist_due = 1'b1;
  endfunction

  // Regenerates the whole state in place, in the same order as the standard
  // algorithm, so later words see the already updated early ones.
  function automatic void twist_words();
    logic [31:0] nx;
    logic [31:0] y;
    logic [31:0] v;
    for (int i = 0; i < NWORDS; i++) begin
      nx = mt_words[(i + 1) % NWORDS];
      y = (mt_words[i] & UPPER_MASK) | (nx & LOWER_MASK);
      v = y >> 1;
      if (nx[0]) v = v ^ mtx_pkg::MATRIX;
      mt_words[i] = v ^ mt_words[(i + mtx_pkg::MID) % NWORDS];
    end
    draw_index = 0;
    twist_due = 1'b0;
  endfunction

  function automatic logic [31:0] temper_word(input logic [31:0] r);
    logic [31:0] t;
    t = r ^ (r >> 11);
    t = t ^ ((t << 7) & mtx_pkg::TEMPER_B);
    t = t ^ ((t << 15) & mtx_pkg::TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  function automatic logic [7:0] xor_with_keystream(input logic [7:0] d, input logic f,
                                                    input logic [31:0] s);
    logic [31:0] w;
    if (f) load_seed(s);
    if (twist_due || draw_index >= NWORDS) twist_words();
    w = temper_word(mt_words[draw_index]);
    draw_index++;
    if (draw_index >= NWORDS) twist_due = 1'b1;
    return d ^ w[8:1];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NWORDS; i++) mt_words[i] = '0;
      draw_index = 0;
      twist_due = 1'b1;
      expected_bytes.delete();
      result_count = 0;
      leftovers_checked = 1'b0;
      errors = 0;
    end else begin
      // Outputs are compared before this edge's input is modeled, since a
      // result can never belong to a byte accepted at the same edge.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("result %0d (%02h) arrived with no byte outstanding",
                                    result_count, out_mon.result_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_mon.result_byte !== want)
            report_mismatch($sformatf("result %0d: result_byte %02h, expected %02h",
                                      result_count, out_mon.result_byte, want));
        end
        result_count++;
      end
      if (in_mon.valid && in_mon.ready)
        expected_bytes.push_back(xor_with_keystream(in_mon.data_byte,
                                                    in_mon.first_of_record, in_mon.seed));
      if (end_check && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_bytes.size() != 0)
          report_mismatch($sformatf("%0d expected results never arrived",
                                    expected_bytes.size()));
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ----- tb/mt19937_byte_keystream_xor_top_test.sv -----
`timescale 1ns / 100ps

// Top of the keystream XOR test. It drives input words, stalls the output
// side, and gives the verdict. All prediction and comparison is done by the
// checker instance, which reports its failure count back up to this level.
module mt19937_byte_keystream_xor_top_test;

  // Number of input words in the random part, on top of the directed part.
  localparam int RANDOM_ITEMS = 1230;
  // The slowest byte is a reseed followed by a full twist, on top of the steps
  // of a plain byte. The watchdog allows several times that, with room for the
  // longest output stall and sender gap.
  localparam int IDLE_LIMIT   = 10000;
  // After the last result, wait out one more worst-case byte time so that a
  // stray extra result would still be caught.
  localparam int DRAIN_CYCLES = 2600;

  typedef enum int {
    RX_FREE,    // always ready
    RX_COIN,    // ready about half of the cycles
    RX_SPARSE,  // ready most of the time, a single-cycle stall now and then
    RX_LONG     // mostly ready, with occasional long stalls
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic drain_done;
  int   checker_errors;
  int   bytes_in_flight;
  int   idle_cycles;

  // Sender burst state and receiver stall state.
  int unsigned burst_left;
  rx_mode_t    rx_mode;
  int unsigned rx_phase_left;
  int unsigned rx_stall_left;

  // Random-part bookkeeping.
  int unsigned sent;
  int unsigned record_no;
  int unsigned record_len;
  logic [7:0]  rnd_byte;
  logic [31:0] rnd_seed;

  mtx_in_if  in_ch();
  mtx_out_if out_ch();

  mt19937_byte_keystream_xor_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mt_keystream_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .end_check (drain_done),
    .errors    (checker_errors),
    .pending   (bytes_in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sends one word. The sender works in bursts: when a burst is used up, valid
  // drops for a random gap (with junk on the payload lines, which the block
  // must ignore) and a new burst length is drawn. The task is entered and left
  // at a falling edge, so valid stays high across back-to-back words without
  // ever being lowered and raised in the same time step.
  task automatic send_byte(input logic [7:0] d, input logic f, input logic [31:0] s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 6);
      in_ch.valid = 1'b0;
      in_ch.data_byte = 8'($urandom);
      in_ch.first_of_record = 1'($urandom);
      in_ch.seed = $urandom;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
    end
    in_ch.valid = 1'b1;
    in_ch.data_byte = d;
    in_ch.first_of_record = f;
    in_ch.seed = s;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  // Receiver: it switches between stall styles at random intervals, so stalls
  // land on reseeds, twists and plain bytes alike, and there are long stretches
  // with no stalls at all.
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(20, 300);
    end
    rx_phase_left--;
    case (rx_mode)
      RX_FREE: begin
        out_ch.ready = 1'b1;
      end
      RX_COIN: begin
        out_ch.ready = 1'($urandom_range(0, 1));
      end
      RX_SPARSE: begin
        out_ch.ready = ($urandom_range(0, 7) != 0);
      end
      default: begin
        if (rx_stall_left > 0) begin
          out_ch.ready = 1'b0;
          rx_stall_left--;
        end else begin
          out_ch.ready = 1'b1;
          if ($urandom_range(0, 9) == 0) rx_stall_left = $urandom_range(5, 40);
        end
      end
    endcase
  end

  // Watchdog: any stretch without a single accepted word on either channel
  // that outlasts the slowest legal byte means the block has hung.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    drain_done = 1'b0;
    idle_cycles = 0;
    burst_left = 0;
    rx_mode = RX_FREE;
    rx_phase_left = 0;
    rx_stall_left = 0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.first_of_record = 1'b0;
    in_ch.seed = '0;
    out_ch.ready = 1'b0;

    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed part. The very first word must reseed, because the state is
    // undefined until then, and it uses the usual default seed. After that: the
    // all-zero and all-one seeds, a lone top bit, extreme data bytes, seeds that
    // must be ignored when the flag is low, and reseeds back to back, including
    // the same seed twice in a row (the second byte must repeat the first).
    send_byte(8'h00, 1'b1, 32'd5489);
    send_byte(8'hff, 1'b0, 32'hffff_ffff);
    send_byte(8'h00, 1'b0, 32'h0000_0000);
    send_byte(8'ha5, 1'b0, 32'h1234_5678);
    send_byte(8'hff, 1'b1, 32'h0000_0000);
    send_byte(8'h5a, 1'b0, 32'd5489);
    send_byte(8'h00, 1'b1, 32'hffff_ffff);
    send_byte(8'h00, 1'b1, 32'hffff_ffff);
    send_byte(8'h80, 1'b1, 32'h8000_0000);
    send_byte(8'h01, 1'b0, 32'h8000_0000);
    send_byte(8'h01, 1'b1, 32'h0000_0001);
    send_byte(8'h7f, 1'b0, 32'hdead_beef);
    send_byte(8'hfe, 1'b0, 32'h0000_0000);
    send_byte(8'h55, 1'b1, 32'haaaa_aaaa);
    send_byte(8'haa, 1'b1, 32'h5555_5555);
    send_byte(8'hff, 1'b0, 32'hffff_ffff);

    // Random part: records of random length, each opening with a reseed from
    // a random seed. Most records are short, some hold a single byte, and the
    // third one runs past the end of the state so that a mid-record twist is
    // exercised. Seeds on continuation bytes are random and must be ignored.
    sent = 0;
    record_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (record_no == 2)
        record_len = mtx_pkg::STATE_WORDS + $urandom_range(1, 100);
      else if ($urandom_range(0, 5) == 0)
        record_len = 1;
      else
        record_len = $urandom_range(2, 60);
      for (int k = 0; k < record_len && sent < RANDOM_ITEMS; k++) begin
        rnd_byte = 8'($urandom);
        if ($urandom_range(0, 7) == 0) rnd_byte = $urandom_range(0, 1) ? 8'hff : 8'h00;
        rnd_seed = $urandom;
        if (k == 0 && $urandom_range(0, 15) == 0)
          rnd_seed = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
        send_byte(rnd_byte, (k == 0), rnd_seed);
        sent++;
      end
      record_no++;
    end
    in_ch.valid = 1'b0;

    // Let every expected word come back, then idle long enough to catch an
    // extra one, and finally have the checker account for leftovers.
    wait (bytes_in_flight == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    drain_done = 1'b1;
    @(negedge clk);

    if (checker_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
